// ----- sv/transfer_segmenter_multi_queue_core_macros.svh -----
// Assertion macros shared by the transfer segmenter RTL.
// Depends on a clk_i clock and an active-low rst_ni reset in the including scope.
`ifndef TRANSFER_SEGMENTER_MULTI_QUEUE_CORE_MACROS_SVH
`define TRANSFER_SEGMENTER_MULTI_QUEUE_CORE_MACROS_SVH

// Same-cycle implication.
`define TSMQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define TSMQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/tsmq_pkg.sv -----
// Shared widths, codes and limits of the transfer segmenter.
// No dependencies; used by tsmq_div and transfer_segmenter_multi_queue_core.
package tsmq_pkg;

  localparam int LEN_W      = 25;
  localparam int KEY_W      = 64;
  localparam int OFS_W      = 48;
  localparam int IMM_W      = 32;
  localparam int OP_W       = 2;
  localparam int QC_W       = 3;
  localparam int MCS_W      = 7;
  localparam int SLOT_OUT_W = 8;
  localparam int QIDX_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 25;
  localparam int IN_DATA_W  = 288;
  localparam int OUT_DATA_W = 296;

  localparam int DIV_NUM_W = LEN_W + 1;
  localparam int DIV_STEP  = 4;

  localparam int DEF_SLOT_RING_DEPTH = 256;
  localparam int DEF_MAX_QUEUES      = 4;

  localparam logic [LEN_W-1:0] MIN_CHUNK = 25'd2097152;
  localparam logic [LEN_W-1:0] MAX_LEN   = 25'd16777216;
  localparam logic [MCS_W-1:0] MCS_MAX   = 7'd64;

  localparam logic [OP_W-1:0] OP_READ      = 2'd0;
  localparam logic [OP_W-1:0] OP_WRITE     = 2'd1;
  localparam logic [OP_W-1:0] OP_WRITE_IMM = 2'd2;
  localparam logic [OP_W-1:0] OP_UNUSED    = 2'd3;

  localparam logic KIND_DESC   = 1'b0;
  localparam logic KIND_COMMIT = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_QUEUE_COUNT         = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_CHUNK_LENGTH    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_CHUNKS_PER_SLOT = 2'd2;

endpackage

// ----- sv/tsmq_div.sv -----
// Iterative unsigned divider, several quotient bits per cycle, for the segmenter.
// Depends on tsmq_pkg for its default widths.
module tsmq_div #(
  parameter int NUM_W = tsmq_pkg::DIV_NUM_W,
  parameter int DEN_W = tsmq_pkg::QC_W,
  parameter int STEP  = tsmq_pkg::DIV_STEP
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quo_o
);

  localparam int CYC   = (NUM_W + STEP - 1) / STEP;
  localparam int PAD_W = CYC * STEP;
  localparam int CNT_W = $clog2(CYC + 1);

  logic [PAD_W-1:0] work_q, work_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;

  always_comb begin
    logic [DEN_W:0]   r;
    logic [PAD_W-1:0] w;
    r = {1'b0, rem_q};
    w = work_q;
    for (int k = 0; k < STEP; k++) begin
      r = {r[DEN_W-1:0], w[PAD_W-1]};
      w = {w[PAD_W-2:0], 1'b0};
      if (r >= {1'b0, den_i}) begin
        r    = r - {1'b0, den_i};
        w[0] = 1'b1;
      end
    end
    work_d = work_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      work_d = PAD_W'(num_i);
      rem_d  = '0;
      cnt_d  = CNT_W'(CYC);
      busy_d = 1'b1;
    end else if (busy_q) begin
      work_d = w;
      rem_d  = r[DEN_W-1:0];
      cnt_d  = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
    rem_q  <= rem_d;
  end

  assign done_o = done_q;
  assign quo_o  = work_q[NUM_W-1:0];

endmodule

// ----- sv/transfer_segmenter_multi_queue_core.sv -----
// Transfer segmenter: cuts transfer requests into chunks, spreads each chunk over
// the queues and batches chunks into ring slots. Depends on tsmq_pkg, tsmq_div and
// transfer_segmenter_multi_queue_core_macros.svh.
//
// One request at a time is taken. Each chunk passes a setup state, then the shared
// divider that computes the per-queue piece length and a load of the quotient,
// then one descriptor per queue and a slot commit when the slot closes. Output
// stalls hold the descriptor and commit states. The next request is accepted
// once its predecessor's last result sits in the output register.
module transfer_segmenter_multi_queue_core #(
  parameter int SLOT_RING_DEPTH = tsmq_pkg::DEF_SLOT_RING_DEPTH,
  parameter int MAX_QUEUES      = tsmq_pkg::DEF_MAX_QUEUES
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [tsmq_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [tsmq_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // op, local_key, remote_key, target offset, source offset, request_length,
  // immediate, zero fill.
  input  logic [tsmq_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  input  logic                             s_axis_tlast,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // slot, queue_index, piece_length, out_local_key, out_remote_key,
  // out_target_offset, out_source_offset, slot_opcode, out_immediate,
  // final_slot, zero fill.
  output logic [tsmq_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  // kind.
  output logic                             m_axis_tuser,
  output logic                             m_axis_tlast
);

  import tsmq_pkg::*;

  `include "transfer_segmenter_multi_queue_core_macros.svh"

  localparam int SLOT_W = $clog2(SLOT_RING_DEPTH);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_CHUNK  = 3'd1;
  localparam logic [2:0] ST_DIV    = 3'd2;
  localparam logic [2:0] ST_DESC   = 3'd3;
  localparam logic [2:0] ST_COMMIT = 3'd4;

  logic [2:0]        state_q, state_d;
  logic [QC_W-1:0]   cfg_qc_q, cfg_qc_d;
  logic [LEN_W-1:0]  cfg_mcl_q, cfg_mcl_d;
  logic [MCS_W-1:0]  cfg_mcs_q, cfg_mcs_d;
  logic [SLOT_W-1:0] slot_cnt_q, slot_cnt_d, cur_slot_q, cur_slot_d;
  logic [MCS_W-1:0]  cis_q, cis_d;
  logic              slot_open_q, slot_open_d;

  logic [OP_W-1:0]   op_q, op_d;
  logic [KEY_W-1:0]  lk_q, lk_d, rk_q, rk_d;
  logic [OFS_W-1:0]  tbase_q, tbase_d, sbase_q, sbase_d;
  logic [OFS_W-1:0]  tchunk_q, tchunk_d, schunk_q, schunk_d;
  logic [LEN_W-1:0]  total_q, total_d, off_q, off_d;
  logic [LEN_W-1:0]  chunk_q, chunk_d, piece_q, piece_d, rel_q, rel_d;
  logic              last_req_q, last_req_d, req_tail_q, req_tail_d;
  logic [IMM_W-1:0]  imm_q, imm_d;
  logic [QC_W-1:0]   q_q, q_d;

  logic                  out_valid_q, out_valid_d;
  logic [OUT_DATA_W-1:0] out_data_q, out_data_d;
  logic                  out_kind_q, out_kind_d, out_last_q, out_last_d;

  logic [QC_W-1:0]      qc;
  logic [LEN_W-1:0]     mcl, remain, chunk_c, desc_len, diff;
  logic [MCS_W-1:0]     mcs, cis_inc;
  logic                 out_free, task_tail, div_start, div_done;
  logic [DIV_NUM_W-1:0] div_quo;
  logic [OP_W-1:0]      opc, in_op;
  logic [LEN_W-1:0]     in_len;

  always_comb begin
    if (cfg_qc_q == '0) begin
      qc = QC_W'(1);
    end else if (int'(cfg_qc_q) > MAX_QUEUES) begin
      qc = QC_W'(MAX_QUEUES);
    end else begin
      qc = cfg_qc_q;
    end
    if (cfg_mcl_q < MIN_CHUNK) begin
      mcl = MIN_CHUNK;
    end else if (cfg_mcl_q > MAX_LEN) begin
      mcl = MAX_LEN;
    end else begin
      mcl = cfg_mcl_q;
    end
    if (cfg_mcs_q == '0) begin
      mcs = MCS_W'(1);
    end else if (cfg_mcs_q > MCS_MAX) begin
      mcs = MCS_MAX;
    end else begin
      mcs = cfg_mcs_q;
    end
  end

  assign remain    = total_q - off_q;
  assign chunk_c   = (remain < mcl) ? remain : mcl;
  assign task_tail = last_req_q && req_tail_q;
  assign out_free  = !out_valid_q || m_axis_tready;
  assign cis_inc   = cis_q + 1'b1;
  assign diff      = chunk_q - rel_q;
  assign desc_len  = (rel_q < chunk_q) ? ((diff > piece_q) ? piece_q : diff) : '0;
  assign opc       = (op_q == OP_WRITE_IMM && !task_tail) ? OP_WRITE : op_q;
  assign div_start = (state_q == ST_CHUNK);
  assign in_op     = (s_axis_tdata[1:0] == OP_UNUSED) ? OP_READ : s_axis_tdata[1:0];
  assign in_len    = (s_axis_tdata[250:226] > MAX_LEN) ? MAX_LEN : s_axis_tdata[250:226];

  tsmq_div #(
    .NUM_W(DIV_NUM_W),
    .DEN_W(QC_W),
    .STEP (DIV_STEP)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (DIV_NUM_W'(chunk_c) + DIV_NUM_W'(qc) - DIV_NUM_W'(1)),
    .den_i  (qc),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  always_comb begin
    cfg_qc_d  = cfg_qc_q;
    cfg_mcl_d = cfg_mcl_q;
    cfg_mcs_d = cfg_mcs_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_QUEUE_COUNT:         cfg_qc_d  = cfg_data_i[QC_W-1:0];
        CFG_MAX_CHUNK_LENGTH:    cfg_mcl_d = cfg_data_i[LEN_W-1:0];
        CFG_MAX_CHUNKS_PER_SLOT: cfg_mcs_d = cfg_data_i[MCS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d     = state_q;
    slot_cnt_d  = slot_cnt_q;
    cur_slot_d  = cur_slot_q;
    cis_d       = cis_q;
    slot_open_d = slot_open_q;
    op_d        = op_q;
    lk_d        = lk_q;
    rk_d        = rk_q;
    tbase_d     = tbase_q;
    sbase_d     = sbase_q;
    tchunk_d    = tchunk_q;
    schunk_d    = schunk_q;
    total_d     = total_q;
    off_d       = off_q;
    chunk_d     = chunk_q;
    piece_d     = piece_q;
    rel_d       = rel_q;
    last_req_d  = last_req_q;
    req_tail_d  = req_tail_q;
    imm_d       = imm_q;
    q_d         = q_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_data_d  = out_data_q;
    out_kind_d  = out_kind_q;
    out_last_d  = out_last_q;

    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          op_d       = in_op;
          lk_d       = s_axis_tdata[65:2];
          rk_d       = s_axis_tdata[129:66];
          tbase_d    = s_axis_tdata[177:130];
          sbase_d    = s_axis_tdata[225:178];
          total_d    = in_len;
          imm_d      = s_axis_tdata[282:251];
          last_req_d = s_axis_tlast;
          off_d      = '0;
          state_d    = ST_CHUNK;
        end
      end
      ST_CHUNK: begin
        chunk_d    = chunk_c;
        req_tail_d = (chunk_c == remain);
        tchunk_d   = tbase_q + OFS_W'(off_q);
        schunk_d   = sbase_q + OFS_W'(off_q);
        if (!slot_open_q) begin
          cur_slot_d  = slot_cnt_q;
          slot_cnt_d  = (slot_cnt_q == SLOT_W'(SLOT_RING_DEPTH - 1)) ? '0
                                                                     : slot_cnt_q + 1'b1;
          cis_d       = '0;
          slot_open_d = 1'b1;
        end
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          piece_d = div_quo[LEN_W-1:0];
          rel_d   = '0;
          q_d     = '0;
          state_d = ST_DESC;
        end
      end
      ST_DESC: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_kind_d  = KIND_DESC;
          out_last_d  = 1'b0;
          out_data_d  = {2'b00, 1'b0, {IMM_W{1'b0}}, OP_READ,
                         schunk_q + OFS_W'(rel_q), tchunk_q + OFS_W'(rel_q),
                         rk_q, lk_q, desc_len, q_q[QIDX_W-1:0],
                         SLOT_OUT_W'(cur_slot_q)};
          q_d   = q_q + 1'b1;
          rel_d = rel_q + piece_q;
          if (q_q == qc - 1'b1) begin
            cis_d = cis_inc;
            if (cis_inc >= mcs || task_tail) begin
              state_d = ST_COMMIT;
            end else if (req_tail_q) begin
              out_last_d = 1'b1;
              state_d    = ST_IDLE;
            end else begin
              off_d   = off_q + chunk_q;
              state_d = ST_CHUNK;
            end
          end
        end
      end
      ST_COMMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_kind_d  = KIND_COMMIT;
          out_last_d  = req_tail_q;
          out_data_d  = {2'b00, task_tail,
                         (opc == OP_WRITE_IMM) ? imm_q : {IMM_W{1'b0}}, opc,
                         {OFS_W{1'b0}}, {OFS_W{1'b0}}, {KEY_W{1'b0}}, {KEY_W{1'b0}},
                         {LEN_W{1'b0}}, {QIDX_W{1'b0}}, SLOT_OUT_W'(cur_slot_q)};
          slot_open_d = 1'b0;
          cis_d       = '0;
          if (req_tail_q) begin
            state_d = ST_IDLE;
          end else begin
            off_d   = off_q + chunk_q;
            state_d = ST_CHUNK;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cfg_qc_q    <= QC_W'(1);
      cfg_mcl_q   <= MIN_CHUNK;
      cfg_mcs_q   <= MCS_MAX;
      slot_cnt_q  <= '0;
      cis_q       <= '0;
      slot_open_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cfg_qc_q    <= cfg_qc_d;
      cfg_mcl_q   <= cfg_mcl_d;
      cfg_mcs_q   <= cfg_mcs_d;
      slot_cnt_q  <= slot_cnt_d;
      cis_q       <= cis_d;
      slot_open_q <= slot_open_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_slot_q <= cur_slot_d;
    op_q       <= op_d;
    lk_q       <= lk_d;
    rk_q       <= rk_d;
    tbase_q    <= tbase_d;
    sbase_q    <= sbase_d;
    tchunk_q   <= tchunk_d;
    schunk_q   <= schunk_d;
    total_q    <= total_d;
    off_q      <= off_d;
    chunk_q    <= chunk_d;
    piece_q    <= piece_d;
    rel_q      <= rel_d;
    last_req_q <= last_req_d;
    req_tail_q <= req_tail_d;
    imm_q      <= imm_d;
    q_q        <= q_d;
    out_data_q <= out_data_d;
    out_kind_q <= out_kind_d;
    out_last_q <= out_last_d;
  end

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = out_last_q;

  `TSMQ_ASSERT_NOW(a_cis_bound, 1'b1, cis_q <= MCS_MAX,
                   "Chunk count of a slot exceeds its bound.")
  `TSMQ_ASSERT_NOW(a_desc_in_open_slot, state_q == ST_DESC || state_q == ST_COMMIT,
                   slot_open_q, "Slot result issued while no slot is open.")
  `TSMQ_ASSERT_NEXT(a_commit_closes, state_q == ST_COMMIT && out_free,
                    !slot_open_q && cis_q == '0, "Slot commit did not close the slot.")
  `TSMQ_ASSERT_NOW(a_piece_bound, state_q == ST_DESC,
                   desc_len <= piece_q && desc_len <= chunk_q,
                   "Descriptor length exceeds piece or chunk.")

endmodule
